>>> hdl/ufcd_pkg.sv
// ----------------------------------------------------------------------------
// ufcd_pkg
// shared widths and constants of the union-find cycle detector
// ----------------------------------------------------------------------------
`default_nettype none

package ufcd_pkg;

   localparam int NODE_W            = 10;
   localparam int COUNT_W           = 11;
   localparam int REQ_DATA_W        = 24;
   localparam int RSP_DATA_W        = 16;
   localparam int MAX_NODES_DEFAULT = 1024;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

endpackage

`default_nettype wire

>>> hdl/ufcd_ram.sv
// ----------------------------------------------------------------------------
// ufcd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ufcd_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hdl/union_find_cycle_detector_unit.sv
// ----------------------------------------------------------------------------
// union_find_cycle_detector_unit
// disjoint-set forest with union by size and full path compression
// ----------------------------------------------------------------------------
// Each transfer on req carries one undirected edge. Both roots are found by
// walking parent links in one ram (one read and one write per cycle), then the
// chain is walked a second time and every node on it is relinked to the root.
// Equal roots mean the edge closes a cycle and the sticky flag is set; else
// the smaller set goes under the larger one; on a tie the first root goes
// under the second. An edge is accepted, each endpoint is walked to its root
// and, when its depth is above zero, its chain is relinked; then the roots
// are linked and the result is handed to the output register. A result still
// waiting on rsp holds the next edge back. An edge with an endpoint at or
// above node_count or MAX_NODES leaves the forest alone. After reset a
// clearing pass over all MAX_NODES entries initializes the ram; no edge is
// taken during it.
// ----------------------------------------------------------------------------
`default_nettype none

module union_find_cycle_detector_unit #(
   parameter int MAX_NODES = ufcd_pkg::MAX_NODES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // first_node [9:0], second_node [19:10]
   input  wire logic [ufcd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // closes_cycle [0], cycle_seen [1], out_of_range [2], merged_root [12:3]
   output      logic [ufcd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_wr_en,
   input  wire logic [ufcd_pkg::COUNT_W-1:0]    csr_wr_data
);

   localparam int NODE_W = ufcd_pkg::NODE_W;
   localparam int CNT_W  = ufcd_pkg::COUNT_W;
   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int SZ_W   = $clog2(MAX_NODES + 1);
   localparam int ENT_W  = SZ_W + 1;
   localparam int PAD_W  = ufcd_pkg::RSP_DATA_W - NODE_W - 3;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_FIX,
      S_LINK,
      S_GROW,
      S_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [IDX_W-1:0]                clr_ff, clr_in;
   logic [IDX_W-1:0]                cur_ff, cur_in;
   logic [IDX_W-1:0]                start_ff, start_in;
   logic [IDX_W-1:0]                b_ff, b_in;
   logic                            which_ff, which_in;
   logic [IDX_W-1:0]                ra_ff, ra_in;
   logic [IDX_W-1:0]                rb_ff, rb_in;
   logic [SZ_W-1:0]                 sa_ff, sa_in;
   logic [SZ_W-1:0]                 sb_ff, sb_in;
   logic                            res_closes_ff, res_closes_in;
   logic                            res_oor_ff, res_oor_in;
   logic [IDX_W-1:0]                res_root_ff, res_root_in;
   logic                            cycle_ff, cycle_in;
   logic [CNT_W-1:0]                node_count_ff, node_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ufcd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [ENT_W-1:0]        wr_data;
   logic [IDX_W-1:0]        rd_addr;
   logic [ENT_W-1:0]        rd_data;

   logic [NODE_W-1:0]       a_node, b_node;
   logic [NODE_W+IDX_W-1:0] a_wide, b_wide;
   logic [IDX_W-1:0]        a_idx, b_idx;
   logic                    a_ok, b_ok;
   logic                    rd_root;
   logic [SZ_W-1:0]         rd_pay;
   logic [IDX_W-1:0]        rd_parent;
   logic [IDX_W-1:0]        found_root;
   logic [NODE_W+IDX_W-1:0] root_wide;
   logic [NODE_W-1:0]       root_port;

   ufcd_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_NODES)
   ) u_forest (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign a_node    = req_tdata[NODE_W-1:0];
   assign b_node    = req_tdata[2*NODE_W-1:NODE_W];
   assign a_wide    = {{IDX_W{1'b0}}, a_node};
   assign b_wide    = {{IDX_W{1'b0}}, b_node};
   assign a_idx     = a_wide[IDX_W-1:0];
   assign b_idx     = b_wide[IDX_W-1:0];
   assign a_ok      = (CNT_W'(a_node) < node_count_ff) && (32'(a_node) < 32'(MAX_NODES));
   assign b_ok      = (CNT_W'(b_node) < node_count_ff) && (32'(b_node) < 32'(MAX_NODES));
   assign rd_root   = rd_data[ENT_W-1];
   assign rd_pay    = rd_data[SZ_W-1:0];
   assign rd_parent = rd_pay[IDX_W-1:0];
   assign found_root = which_ff ? rb_ff : ra_ff;
   assign root_wide = {{NODE_W{1'b0}}, res_root_ff};
   assign root_port = root_wide[NODE_W-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      b_in          = b_ff;
      which_in      = which_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      sa_in         = sa_ff;
      sb_in         = sb_ff;
      res_closes_in = res_closes_ff;
      res_oor_in    = res_oor_ff;
      res_root_in   = res_root_ff;
      cycle_in      = cycle_ff;
      node_count_in = node_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = '0;
      rd_addr       = cur_ff;
      req_tready    = 1'b0;

      if (csr_wr_en) begin
         node_count_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {1'b1, SZ_W'(1)};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            rd_addr    = a_idx;
            if (req_tvalid) begin
               if (!(a_ok && b_ok)) begin
                  res_oor_in    = 1'b1;
                  res_closes_in = 1'b0;
                  res_root_in   = '0;
                  state_in      = S_DONE;
               end else begin
                  res_oor_in = 1'b0;
                  cur_in     = a_idx;
                  start_in   = a_idx;
                  b_in       = b_idx;
                  which_in   = 1'b0;
                  state_in   = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (rd_root) begin
               if (which_ff) begin
                  rb_in = cur_ff;
                  sb_in = rd_pay;
               end else begin
                  ra_in = cur_ff;
                  sa_in = rd_pay;
               end
               if (start_ff == cur_ff) begin
                  if (which_ff) begin
                     state_in = S_LINK;
                  end else begin
                     which_in = 1'b1;
                     cur_in   = b_ff;
                     start_in = b_ff;
                     rd_addr  = b_ff;
                  end
               end else begin
                  cur_in   = start_ff;
                  rd_addr  = start_ff;
                  state_in = S_FIX;
               end
            end else begin
               cur_in  = rd_parent;
               rd_addr = rd_parent;
            end
         end
         S_FIX: begin
            if (rd_root) begin
               if (which_ff) begin
                  state_in = S_LINK;
               end else begin
                  which_in = 1'b1;
                  cur_in   = b_ff;
                  start_in = b_ff;
                  rd_addr  = b_ff;
                  state_in = S_WALK;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = {1'b0, SZ_W'(found_root)};
               cur_in  = rd_parent;
               rd_addr = rd_parent;
            end
         end
         S_LINK: begin
            if (ra_ff == rb_ff) begin
               res_closes_in = 1'b1;
               cycle_in      = 1'b1;
               res_root_in   = ra_ff;
               state_in      = S_DONE;
            end else begin
               res_closes_in = 1'b0;
               wr_en         = 1'b1;
               state_in      = S_GROW;
               if (sa_ff > sb_ff) begin
                  wr_addr     = rb_ff;
                  wr_data     = {1'b0, SZ_W'(ra_ff)};
                  res_root_in = ra_ff;
               end else begin
                  wr_addr     = ra_ff;
                  wr_data     = {1'b0, SZ_W'(rb_ff)};
                  res_root_in = rb_ff;
               end
            end
         end
         S_GROW: begin
            wr_en    = 1'b1;
            wr_addr  = res_root_ff;
            wr_data  = {1'b1, sa_ff + sb_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, root_port, res_oor_ff, cycle_ff, res_closes_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         cycle_ff      <= 1'b0;
         node_count_ff <= ufcd_pkg::NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cycle_ff      <= cycle_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      start_ff      <= start_in;
      b_ff          <= b_in;
      which_ff      <= which_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      sa_ff         <= sa_in;
      sb_ff         <= sb_in;
      res_closes_ff <= res_closes_in;
      res_oor_ff    <= res_oor_in;
      res_root_ff   <= res_root_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // sticky cycle flag never drops
   a_cycle_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(cycle_ff) && !$past(reset) |-> cycle_ff)
      else $error("cycle flag dropped");

   // a result that closes a cycle reports the flag as set
   a_closes_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[0] |-> rsp_data_ff[1])
      else $error("closing edge without cycle_seen");

   // an ignored edge reports no closed cycle and root zero
   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[2] |-> !rsp_data_ff[0] && rsp_data_ff[12:3] == '0)
      else $error("out of range result carries data");

   // the forest is not written while waiting for an edge, walking to a root or handing off a result
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE || state_ff == S_WALK || state_ff == S_DONE |-> !wr_en)
      else $error("forest write outside update states");

endmodule

`default_nettype wire
